// File: rtl/crt_pkg.sv
// Shared types and constants for the CSV row tokenizer.
package crt_pkg;

	// Default sizing handed to the top level
	localparam int DEF_MAX_FIELDS  = 8;
	localparam int DEF_FIELD_BYTES = 4096;

	// Characters with a meaning to the parser
	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_QUOTE = 8'd34;
	localparam logic [7:0] CH_COMMA = 8'd44;

	// Parser phase within a row
	typedef enum logic [2:0] {
		PH_START  = 3'd0,
		PH_PLAIN  = 3'd1,
		PH_QUOTED = 3'd2,
		PH_QSEEN  = 3'd3,
		PH_SKIP   = 3'd4
	} crt_phase_t;

	// Fault codes
	typedef enum logic [1:0] {
		ERR_UNBALANCED = 2'd0,
		ERR_FIELDS     = 2'd1,
		ERR_LENGTH     = 2'd2,
		ERR_STRAY      = 2'd3
	} crt_err_t;

	// One input byte of text
	typedef struct packed {
		logic [7:0] byte_value;
		logic       last_byte;
	} crt_item_t;

	// One result token
	typedef struct packed {
		logic        has_byte;
		logic [7:0]  out_byte;
		logic [2:0]  field_index;
		logic        field_end;
		logic [11:0] field_length;
		logic        row_end;
		logic        error_flag;
		crt_err_t    error_code;
	} crt_res_t;

endpackage

// File: rtl/csv_row_tokenizer_top.sv
// Top level of the CSV row tokenizer: stream ports, input and result registers.
//
// Usage: CSV text enters one byte per request on the s_ channel; s_tlast flags
// the final byte of the data. Tokens leave on the m_ channel: a content byte
// with its field index, a field end with the field length, a row end (m_tlast)
// on the field that closes a row, or a single error token.
// Path: an accepted byte is held in the input register, decoded from it by
// crt_parse_core, and its token is loaded into the result register that drives m_tvalid.
// Bytes that produce no token (quotes, empty rows, skipped text) are absorbed without output.
// Throughput: one byte per cycle while the result register is free or being drained;
// the only loop is the parser state update in crt_parse_core.
// Reset: arst_n clears the parser to the start of a row, drops any pending
// byte and token, and clears a latched fault.
// Stall: while m_tready is low and a token is held, the parser stage halts and
// s_tready falls once the input register is occupied; no byte is lost.
// A fault emits one error token; all later bytes are accepted and dropped.
module csv_row_tokenizer_top #(
	parameter int MAX_FIELDS  = crt_pkg::DEF_MAX_FIELDS,
	parameter int FIELD_BYTES = crt_pkg::DEF_FIELD_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,  // [7:0] byte_value
	input  logic        s_tlast,  // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,  // [7:0] out_byte, [10:8] field_index,
	                              // [22:11] field_length, [24:23] error_code, zero fill
	output logic [2:0]  m_tuser,  // [0] has_byte, [1] field_end, [2] error_flag
	output logic        m_tlast   // row_end
);

	logic               valid_s1;
	crt_pkg::crt_item_t item_s1;
	logic               out_valid_q;
	crt_pkg::crt_res_t  res_q;
	logic               advance, emit;
	crt_pkg::crt_res_t  res;

	// Result slot is free or being drained this cycle
	assign advance  = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.byte_value <= s_tdata;
			item_s1.last_byte  <= s_tlast;
		end
	end

	crt_parse_core #(
		.MAX_FIELDS  (MAX_FIELDS),
		.FIELD_BYTES (FIELD_BYTES)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (valid_s1 && advance),
		.item   (item_s1),
		.emit   (emit),
		.res    (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1 && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res;
		end
	end

	// Pack the token onto the master side
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, res_q.error_code, res_q.field_length,
	                   res_q.field_index, res_q.out_byte};
	assign m_tuser  = {res_q.error_flag, res_q.field_end, res_q.has_byte};
	assign m_tlast  = res_q.row_end;

endmodule

// File: rtl/crt_parse_core.sv
// Parser state and per-byte token decode for the CSV row tokenizer.
module crt_parse_core #(
	parameter int MAX_FIELDS  = crt_pkg::DEF_MAX_FIELDS,
	parameter int FIELD_BYTES = crt_pkg::DEF_FIELD_BYTES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               step,
	input  crt_pkg::crt_item_t item,
	output logic               emit,
	output crt_pkg::crt_res_t  res
);

	localparam int FW = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
	localparam int LW = $clog2(FIELD_BYTES);

	crt_pkg::crt_phase_t phase_q, nxt_phase;
	logic [FW-1:0] field_q, nxt_field;
	logic [LW-1:0] len_q, nxt_len, len_inc, rep_len;
	logic          started_q, nxt_started;
	logic          fault_q, nxt_fault;

	logic [7:0]  b;
	logic        last;
	logic        ender, skip, is_quote, is_comma;
	logic        at_max_field, len_full;
	logic        take_comma, take_plain, take_quoted, close, err, close_has;
	crt_pkg::crt_err_t err_code;
	logic [31:0] fidx_ext, len_ext;

	assign b        = item.byte_value;
	assign last     = item.last_byte;
	assign ender    = (b == crt_pkg::CH_NL) || (b == 8'd0);
	assign skip     = (b == 8'd0) && !last;
	assign is_quote = (b == crt_pkg::CH_QUOTE);
	assign is_comma = (b == crt_pkg::CH_COMMA);

	assign at_max_field = (field_q == FW'(MAX_FIELDS - 1));
	assign len_full     = (len_q >= LW'(FIELD_BYTES - 1));
	assign len_inc      = len_q + 1'b1;
	assign fidx_ext     = 32'(field_q);
	assign len_ext      = 32'(rep_len);

	// Hold parser state; advance only on a consumed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= crt_pkg::PH_START;
			field_q   <= '0;
			len_q     <= '0;
			started_q <= 1'b0;
			fault_q   <= 1'b0;
		end else begin
			phase_q   <= nxt_phase;
			field_q   <= nxt_field;
			len_q     <= nxt_len;
			started_q <= nxt_started;
			fault_q   <= nxt_fault;
		end
	end

	// Decode the byte against the current phase
	always_comb begin
		nxt_phase   = phase_q;
		nxt_field   = field_q;
		nxt_len     = len_q;
		nxt_started = started_q;
		nxt_fault   = fault_q;
		take_comma  = 1'b0;
		take_plain  = 1'b0;
		take_quoted = 1'b0;
		close       = 1'b0;
		close_has   = 1'b0;
		err         = 1'b0;
		err_code    = crt_pkg::ERR_UNBALANCED;
		rep_len     = len_q;
		emit        = 1'b0;
		res         = '0;
		res.field_index = fidx_ext[2:0];

		if (step && !fault_q) begin
			case (phase_q)
				crt_pkg::PH_START: begin
					if (ender) begin
						if (!started_q) begin
							// empty row: no token
							nxt_phase   = skip ? crt_pkg::PH_SKIP : crt_pkg::PH_START;
							nxt_field   = '0;
							nxt_len     = '0;
							nxt_started = 1'b0;
						end else begin
							close = 1'b1;
						end
					end else begin
						nxt_started = 1'b1;
						if (is_quote) begin
							if (last) begin
								err      = 1'b1;
								err_code = crt_pkg::ERR_UNBALANCED;
							end else begin
								nxt_phase = crt_pkg::PH_QUOTED;
							end
						end else if (is_comma) begin
							take_comma = 1'b1;
						end else begin
							nxt_phase  = crt_pkg::PH_PLAIN;
							take_plain = 1'b1;
						end
					end
				end
				crt_pkg::PH_PLAIN: begin
					if (ender) begin
						close = 1'b1;
					end else if (is_comma) begin
						take_comma = 1'b1;
					end else begin
						take_plain = 1'b1;
					end
				end
				crt_pkg::PH_QUOTED: begin
					if (ender) begin
						err      = 1'b1;
						err_code = crt_pkg::ERR_UNBALANCED;
					end else if (is_quote) begin
						if (last) begin
							close = 1'b1;
						end else begin
							nxt_phase = crt_pkg::PH_QSEEN;
						end
					end else begin
						take_quoted = 1'b1;
					end
				end
				crt_pkg::PH_QSEEN: begin
					if (is_quote) begin
						// doubled quote: one literal quote
						take_quoted = 1'b1;
						nxt_phase   = crt_pkg::PH_QUOTED;
					end else if (is_comma) begin
						take_comma = 1'b1;
					end else if (ender) begin
						close = 1'b1;
					end else begin
						err      = 1'b1;
						err_code = crt_pkg::ERR_STRAY;
					end
				end
				crt_pkg::PH_SKIP: begin
					// drop bytes up to the end of the line
					if ((b == crt_pkg::CH_NL) || last) begin
						nxt_phase   = crt_pkg::PH_START;
						nxt_field   = '0;
						nxt_len     = '0;
						nxt_started = 1'b0;
					end
				end
				default: begin
					nxt_phase = crt_pkg::PH_START;
				end
			endcase
		end

		// Comma: close the field, open the next one (row end if flagged last, fault at the field limit)
		if (take_comma) begin
			if (at_max_field) begin
				err      = 1'b1;
				err_code = crt_pkg::ERR_FIELDS;
			end else if (last) begin
				close = 1'b1;
			end else begin
				emit             = 1'b1;
				res.field_end    = 1'b1;
				res.field_length = len_ext[11:0];
				nxt_field        = field_q + 1'b1;
				nxt_len          = '0;
				nxt_phase        = crt_pkg::PH_START;
			end
		end

		// Content byte: grow the field (fault when full; if flagged last, row end when plain, fault when quoted)
		if (take_plain || take_quoted) begin
			if (len_full) begin
				err      = 1'b1;
				err_code = crt_pkg::ERR_LENGTH;
			end else begin
				nxt_len = len_inc;
				rep_len = len_inc;
				if (last) begin
					if (take_plain) begin
						close     = 1'b1;
						close_has = 1'b1;
					end else begin
						err      = 1'b1;
						err_code = crt_pkg::ERR_UNBALANCED;
					end
				end else begin
					emit         = 1'b1;
					res.has_byte = 1'b1;
					res.out_byte = b;
				end
			end
		end

		// Row end: report the last field and restart the row
		if (close) begin
			emit             = 1'b1;
			res.has_byte     = close_has;
			res.out_byte     = close_has ? b : 8'd0;
			res.field_end    = 1'b1;
			res.field_length = len_ext[11:0];
			res.row_end      = 1'b1;
			nxt_phase        = skip ? crt_pkg::PH_SKIP : crt_pkg::PH_START;
			nxt_field        = '0;
			nxt_len          = '0;
			nxt_started      = 1'b0;
		end

		// Fault: one error token, then latch
		if (err) begin
			emit           = 1'b1;
			res            = '0;
			res.error_flag = 1'b1;
			res.error_code = err_code;
			nxt_fault      = 1'b1;
		end
	end

	// Fault stays latched until reset
	a_fault_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		fault_q |=> fault_q)
		else $error("fault flag cleared without reset");

	// Nothing is emitted once a fault is latched
	a_quiet_after_fault: assert property (@(posedge clk) disable iff (!arst_n)
		fault_q |-> !emit)
		else $error("token emitted after fault");

	// Field counter stays within the row limit
	a_field_range: assert property (@(posedge clk) disable iff (!arst_n)
		field_q <= FW'(MAX_FIELDS - 1))
		else $error("field index beyond limit");

	// A skipped line never counts as a started row
	a_skip_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == crt_pkg::PH_SKIP) |-> (!started_q && field_q == '0 && len_q == '0))
		else $error("skip phase with open row state");

endmodule

// File: dv/tb_csv_row_tokenizer_top.sv
// Self-checking stream testbench for the CSV row tokenizer top level.
`timescale 1ns / 1ps

module tb_csv_row_tokenizer_top;

	localparam int N_FIELDS   = crt_pkg::DEF_MAX_FIELDS;
	localparam int N_BYTES    = crt_pkg::DEF_FIELD_BYTES;
	localparam int STALL_LIMIT = 2000;
	localparam int TAIL_CYCLES = 20;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'h00;
	logic        s_tlast   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [31:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	// Tokens predicted but not yet seen, and the text line being assembled
	crt_pkg::crt_res_t   token_q[$];
	crt_pkg::crt_item_t  line_q[$];

	int fail_count    = 0;
	int bytes_sent    = 0;
	int idle_cycles   = 0;
	int src_idle_pct  = 0;
	int sink_idle_pct = 0;

	// Tokenizer state mirrored by the predictor
	crt_pkg::crt_phase_t tk_phase   = crt_pkg::PH_START;
	int unsigned         tk_field   = 0;
	int unsigned         tk_len     = 0;
	bit                  tk_started = 1'b0;
	bit                  tk_fault   = 1'b0;

	csv_row_tokenizer_top #(
		.MAX_FIELDS  (N_FIELDS),
		.FIELD_BYTES (N_BYTES)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------- predictor

	function automatic void emit_token(bit has, logic [7:0] b, bit fend, bit rend);
		crt_pkg::crt_res_t t;
		t = '0;
		t.has_byte     = has;
		t.out_byte     = has ? b : 8'h00;
		t.field_index  = tk_field[2:0];
		t.field_end    = fend;
		t.field_length = fend ? tk_len[11:0] : 12'd0;
		t.row_end      = rend;
		token_q.push_back(t);
	endfunction

	function automatic void emit_fault(crt_pkg::crt_err_t code);
		crt_pkg::crt_res_t t;
		t = '0;
		t.error_flag = 1'b1;
		t.error_code = code;
		token_q.push_back(t);
		tk_fault = 1'b1;
	endfunction

	function automatic void restart_row(bit skip_rest);
		tk_phase   = skip_rest ? crt_pkg::PH_SKIP : crt_pkg::PH_START;
		tk_field   = 0;
		tk_len     = 0;
		tk_started = 1'b0;
	endfunction

	function automatic void finish_row(bit has, logic [7:0] b, bit skip_rest);
		emit_token(has, b, 1'b1, 1'b1);
		restart_row(skip_rest);
	endfunction

	// Close the field on a comma; a comma flagged last closes the row too
	function automatic void take_comma(bit last);
		if (tk_field + 1 >= N_FIELDS) begin
			emit_fault(crt_pkg::ERR_FIELDS);
		end else if (last) begin
			finish_row(1'b0, 8'h00, 1'b0);
		end else begin
			emit_token(1'b0, 8'h00, 1'b1, 1'b0);
			tk_field++;
			tk_len   = 0;
			tk_phase = crt_pkg::PH_START;
		end
	endfunction

	function automatic bit grow_field();
		if (tk_len + 1 >= N_BYTES)
			return 1'b0;
		tk_len++;
		return 1'b1;
	endfunction

	function automatic void plain_step(logic [7:0] b, bit last, bit ender, bit skip);
		if (ender)
			finish_row(1'b0, 8'h00, skip);
		else if (b == crt_pkg::CH_COMMA)
			take_comma(last);
		else if (!grow_field())
			emit_fault(crt_pkg::ERR_LENGTH);
		else if (last)
			finish_row(1'b1, b, 1'b0);
		else
			emit_token(1'b1, b, 1'b0, 1'b0);
	endfunction

	// Advance the tokenizer by one accepted byte and queue its token, if any
	function automatic void tokenize_byte(logic [7:0] b, bit last);
		bit ender;
		bit skip;
		ender = (b == crt_pkg::CH_NL) || (b == 8'h00);
		skip  = (b == 8'h00) && !last;
		if (tk_fault)
			return;
		case (tk_phase)
			crt_pkg::PH_START: begin
				if (ender) begin
					if (!tk_started)
						restart_row(skip);
					else
						finish_row(1'b0, 8'h00, skip);
				end else begin
					tk_started = 1'b1;
					if (b == crt_pkg::CH_QUOTE) begin
						if (last)
							emit_fault(crt_pkg::ERR_UNBALANCED);
						else
							tk_phase = crt_pkg::PH_QUOTED;
					end else if (b == crt_pkg::CH_COMMA) begin
						take_comma(last);
					end else begin
						tk_phase = crt_pkg::PH_PLAIN;
						plain_step(b, last, ender, skip);
					end
				end
			end
			crt_pkg::PH_PLAIN: plain_step(b, last, ender, skip);
			crt_pkg::PH_QUOTED: begin
				if (ender) begin
					emit_fault(crt_pkg::ERR_UNBALANCED);
				end else if (b == crt_pkg::CH_QUOTE) begin
					if (last)
						finish_row(1'b0, 8'h00, 1'b0);
					else
						tk_phase = crt_pkg::PH_QSEEN;
				end else if (!grow_field()) begin
					emit_fault(crt_pkg::ERR_LENGTH);
				end else if (last) begin
					emit_fault(crt_pkg::ERR_UNBALANCED);
				end else begin
					emit_token(1'b1, b, 1'b0, 1'b0);
				end
			end
			crt_pkg::PH_QSEEN: begin
				if (b == crt_pkg::CH_QUOTE) begin
					if (!grow_field()) begin
						emit_fault(crt_pkg::ERR_LENGTH);
					end else if (last) begin
						emit_fault(crt_pkg::ERR_UNBALANCED);
					end else begin
						tk_phase = crt_pkg::PH_QUOTED;
						emit_token(1'b1, crt_pkg::CH_QUOTE, 1'b0, 1'b0);
					end
				end else if (b == crt_pkg::CH_COMMA) begin
					take_comma(last);
				end else if (ender) begin
					finish_row(1'b0, 8'h00, skip);
				end else begin
					emit_fault(crt_pkg::ERR_STRAY);
				end
			end
			default: begin
				if (b == crt_pkg::CH_NL || last)
					restart_row(1'b0);
			end
		endcase
	endfunction

	// ---------------------------------------------------------------- text builders

	function automatic logic [7:0] plain_byte(bit first);
		logic [7:0] b;
		do
			b = 8'($urandom_range(255));
		while (b == 8'h00 || b == crt_pkg::CH_NL || b == crt_pkg::CH_COMMA ||
		       (first && b == crt_pkg::CH_QUOTE));
		return b;
	endfunction

	function automatic void push_byte(logic [7:0] b, bit last);
		crt_pkg::crt_item_t it;
		it.byte_value = b;
		it.last_byte  = last;
		line_q.push_back(it);
	endfunction

	// Quoted content: anything but newline and zero, quotes doubled
	function automatic void push_quoted_content(int n);
		logic [7:0] b;
		repeat (n) begin
			do
				b = 8'($urandom_range(255));
			while (b == 8'h00 || b == crt_pkg::CH_NL);
			push_byte(b, 1'b0);
			if (b == crt_pkg::CH_QUOTE)
				push_byte(crt_pkg::CH_QUOTE, 1'b0);
		end
	endfunction

	function automatic void push_plain_content(int n);
		for (int i = 0; i < n; i++)
			push_byte(plain_byte(i == 0), 1'b0);
	endfunction

	// Skipped text after a zero byte: never a newline, never flagged last
	function automatic void push_junk(int n);
		logic [7:0] b;
		repeat (n) begin
			do
				b = 8'($urandom_range(255));
			while (b == crt_pkg::CH_NL);
			push_byte(b, 1'b0);
		end
	endfunction

	// ---------------------------------------------------------------- stimulus

	task automatic send_byte(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		s_tlast  <= last;
		do
			@(posedge clk);
		while (!s_tready);
		tokenize_byte(b, last);
		bytes_sent++;
	endtask

	task automatic send_line();
		foreach (line_q[i])
			send_byte(line_q[i].byte_value, line_q[i].last_byte);
		line_q.delete();
	endtask

	// Hold the sender off until every predicted token has come out
	task automatic drain_tokens();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (token_q.size() != 0)
			@(posedge clk);
	endtask

	// One well-formed row with random content and a random way of ending it
	task automatic send_random_row();
		int n_fields;
		int ending;
		n_fields = ($urandom_range(7) == 0) ? N_FIELDS : $urandom_range(1, 4);
		for (int i = 0; i < n_fields; i++) begin
			if ($urandom_range(2) == 0) begin
				push_byte(crt_pkg::CH_QUOTE, 1'b0);
				push_quoted_content($urandom_range(0, 6));
				push_byte(crt_pkg::CH_QUOTE, 1'b0);
			end else begin
				push_plain_content($urandom_range(0, 8));
			end
			if (i < n_fields - 1)
				push_byte(crt_pkg::CH_COMMA, 1'b0);
		end
		ending = $urandom_range(4);
		case (ending)
			0: push_byte(crt_pkg::CH_NL, 1'b0);
			1: begin
				push_byte(8'h00, 1'b0);
				push_junk($urandom_range(0, 5));
				push_byte(crt_pkg::CH_NL, 1'b0);
			end
			2: push_byte(8'h00, 1'b1);
			3: begin
				if (line_q.size() == 0)
					push_byte(crt_pkg::CH_NL, 1'b0);
				else
					line_q[line_q.size() - 1].last_byte = 1'b1;
			end
			default: begin
				push_byte(8'h00, 1'b0);
				push_junk($urandom_range(0, 5));
				push_byte(plain_byte(1'b0), 1'b1);
			end
		endcase
		send_line();
	endtask

	task automatic test_directed();
		// empty rows: a bare newline, and a zero byte whose line is skipped
		push_byte(crt_pkg::CH_NL, 1'b0);
		push_byte(8'h00, 1'b0);
		push_byte(crt_pkg::CH_QUOTE, 1'b0);
		push_byte(crt_pkg::CH_NL, 1'b0);
		// extreme bytes, carriage return as content, trailing comma
		push_byte(8'hFF, 1'b0);
		push_byte(8'h0D, 1'b0);
		push_byte(8'h01, 1'b0);
		push_byte(crt_pkg::CH_COMMA, 1'b0);
		push_byte(crt_pkg::CH_NL, 1'b0);
		// quoted field with a doubled quote and an inner comma, then a comma flagged last
		push_byte(crt_pkg::CH_QUOTE, 1'b0);
		push_byte(8'h78, 1'b0);
		push_byte(crt_pkg::CH_QUOTE, 1'b0);
		push_byte(crt_pkg::CH_QUOTE, 1'b0);
		push_byte(crt_pkg::CH_COMMA, 1'b0);
		push_byte(crt_pkg::CH_QUOTE, 1'b0);
		push_byte(crt_pkg::CH_COMMA, 1'b1);
		// all eight fields; content byte flagged last in the final one
		repeat (N_FIELDS - 1)
			push_byte(crt_pkg::CH_COMMA, 1'b0);
		push_byte(8'h7A, 1'b1);
		// closing quote flagged last
		push_byte(crt_pkg::CH_QUOTE, 1'b0);
		push_byte(8'h71, 1'b0);
		push_byte(crt_pkg::CH_QUOTE, 1'b1);
		// zero byte flagged last ends the row with no skip
		push_byte(8'h6B, 1'b0);
		push_byte(8'h00, 1'b1);
		send_line();
	endtask

	// Longest legal field: length field all ones
	task automatic test_long_field();
		push_plain_content(N_BYTES - 1);
		push_byte(crt_pkg::CH_NL, 1'b0);
		send_line();
	endtask

	task automatic test_random_rows(input int n_bytes);
		int start;
		start = bytes_sent;
		while (bytes_sent - start < n_bytes)
			send_random_row();
	endtask

	// A fault is sticky until reset, so one kind is picked per run
	task automatic test_fault();
		crt_pkg::crt_err_t kind;
		int                variant;
		kind = crt_pkg::crt_err_t'($urandom_range(3));
		case (kind)
			crt_pkg::ERR_UNBALANCED: begin
				variant = $urandom_range(3);
				if (variant == 3) begin
					push_byte(crt_pkg::CH_QUOTE, 1'b1);
				end else begin
					push_byte(crt_pkg::CH_QUOTE, 1'b0);
					push_quoted_content($urandom_range(1, 4));
					case (variant)
						0: push_byte(crt_pkg::CH_NL, 1'b0);
						1: push_byte(8'h00, 1'b0);
						default: push_byte(8'(8'h41 + $urandom_range(25)), 1'b1);
					endcase
				end
			end
			crt_pkg::ERR_FIELDS: begin
				repeat (N_FIELDS) begin
					push_plain_content($urandom_range(0, 2));
					push_byte(crt_pkg::CH_COMMA, 1'b0);
				end
			end
			crt_pkg::ERR_LENGTH: push_plain_content(N_BYTES);
			default: begin
				push_byte(crt_pkg::CH_QUOTE, 1'b0);
				push_quoted_content($urandom_range(0, 3));
				push_byte(crt_pkg::CH_QUOTE, 1'b0);
				push_byte(8'(8'h41 + $urandom_range(25)), 1'b0);
			end
		endcase
		// everything after the fault is dropped
		repeat (16)
			push_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
		send_line();
	endtask

	// ---------------------------------------------------------------- checking

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endfunction

	// Drive the sink ready, compare each token, and watch for a stalled run
	always @(posedge clk) begin : token_check
		crt_pkg::crt_res_t want;
		m_tready <= ($urandom_range(99) >= sink_idle_pct);
		if (arst_n && m_tvalid && m_tready) begin
			if (token_q.size() == 0) begin
				$error("unexpected token: tdata %h tuser %b tlast %b",
				       m_tdata, m_tuser, m_tlast);
				fail_count++;
			end else begin
				want = token_q.pop_front();
				check_field("has_byte", 32'(want.has_byte), 32'(m_tuser[0]));
				check_field("out_byte", 32'(want.out_byte), 32'(m_tdata[7:0]));
				check_field("field_index", 32'(want.field_index), 32'(m_tdata[10:8]));
				check_field("field_end", 32'(want.field_end), 32'(m_tuser[1]));
				check_field("field_length", 32'(want.field_length), 32'(m_tdata[22:11]));
				check_field("row_end", 32'(want.row_end), 32'(m_tlast));
				check_field("error_flag", 32'(want.error_flag), 32'(m_tuser[2]));
				check_field("error_code", 32'(want.error_code), 32'(m_tdata[24:23]));
				check_field("tdata_fill", 32'd0, 32'(m_tdata[31:25]));
			end
		end
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("** csv_row_tokenizer_top: FAILED **");
			$finish;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		src_idle_pct  = 10;
		sink_idle_pct = 65;
		test_directed();
		test_long_field();
		drain_tokens();
		test_random_rows(170);
		drain_tokens();

		src_idle_pct  = 65;
		sink_idle_pct = 10;
		test_random_rows(170);
		drain_tokens();

		src_idle_pct  = 0;
		sink_idle_pct = 0;
		test_random_rows(170);
		test_fault();
		drain_tokens();

		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && token_q.size() == 0)
			$display("** csv_row_tokenizer_top: PASSED **");
		else
			$display("** csv_row_tokenizer_top: FAILED **");
		$finish;
	end

endmodule
